// ----- hw/rtl/lge_pkg.sv -----
// Shared types and constants of the life grid engine.
// No dependencies; imported by lge_cell and life_grid_engine_core.
package lge_pkg;

  localparam int DEF_MAX_WIDTH  = 64;
  localparam int DEF_MAX_HEIGHT = 64;

  localparam int CFG_W    = 7;
  localparam int CFG_IDXW = 1;

  localparam logic [CFG_W-1:0] GRID_DIM_RST = 7'd64;

  localparam logic [CFG_IDXW-1:0] CFG_GRID_WIDTH  = 1'd0;
  localparam logic [CFG_IDXW-1:0] CFG_GRID_HEIGHT = 1'd1;

  localparam logic [3:0] LIFE_BIRTH   = 4'd3;
  localparam logic [3:0] LIFE_SURVIVE = 4'd2;

  typedef enum logic [1:0] {
    ACT_WRITE = 2'd0,
    ACT_READ  = 2'd1,
    ACT_CLEAR = 2'd2,
    ACT_STEP  = 2'd3
  } lge_act_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RMW,
    ST_SWEEP,
    ST_RESP
  } lge_state_e;

  typedef struct packed {
    logic init;
    logic shift;
  } lge_cell_ctrl_t;

endpackage

// ----- hw/rtl/lge_cell.sv -----
// One column cell of the generation chain: holds a three-row window of its column
// and works out the next state from its own and its neighbours' columns. Uses lge_pkg.
module lge_cell import lge_pkg::*; (
  input  logic           clk_i,
  input  lge_cell_ctrl_t ctrl_i,
  input  logic           act_i,
  input  logic           bit_i,
  input  logic [2:0]     left_i,
  input  logic [2:0]     right_i,
  output logic [2:0]     col_o,
  output logic           next_o
);

  logic top_q, mid_q, bot_q;
  logic [3:0] nbr_cnt;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.init) begin
      top_q <= 1'b0;
      mid_q <= 1'b0;
      bot_q <= 1'b0;
    end else if (ctrl_i.shift) begin
      top_q <= mid_q;
      mid_q <= bot_q;
      bot_q <= act_i & bit_i;
    end
  end

  assign col_o = {bot_q, mid_q, top_q};

  always_comb begin
    nbr_cnt = 4'(left_i[0]) + 4'(left_i[1]) + 4'(left_i[2])
            + 4'(right_i[0]) + 4'(right_i[1]) + 4'(right_i[2])
            + 4'(top_q) + 4'(bot_q);
    next_o = act_i & ((nbr_cnt == LIFE_BIRTH) | (mid_q & (nbr_cnt == LIFE_SURVIVE)));
  end

endmodule

// ----- hw/rtl/life_grid_engine_core.sv -----
// Top level of the life grid engine: row memory, sweep sequencer and the chain of cells.
// Depends on lge_pkg and lge_cell.
//
// Bounded Conway grid (B3/S23), cleared at reset, no wraparound. Each input beat writes,
// reads, clears or advances one generation and gives exactly one output beat. A write or
// read goes through the read-modify-write and response states to the output register;
// clear and out-of-range accesses go straight to the response state. For an advance the
// sequencer reads one grid row a cycle from the row memory into the cell chain, which
// holds a three-row window and writes one finished row back per cycle. One item is worked
// on at a time; a new beat is taken while a finished result still waits on the output.
module life_grid_engine_core import lge_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [15:0]         s_axis_tdata,  // action[1:0], col[7:2], row[13:8], cell_value[14]
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [7:0]          m_axis_tdata,  // cell_alive[0], out_of_range[1]
  input  logic                cfg_we_i,
  input  logic [CFG_IDXW-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]    cfg_data_i
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int KW = $clog2(MAX_HEIGHT + 3);

  logic [CFG_W-1:0] grid_width_q, grid_height_q;

  lge_state_e state_q, state_d;
  lge_act_e   op_q, op_d;
  logic [CW-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d;
  logic          val_q, val_d;
  logic [KW-1:0] k_q, k_d;
  logic          res_alive_q, res_alive_d;
  logic          res_oor_q, res_oor_d;

  logic          out_valid_q;
  logic          out_alive_q, out_oor_q;
  logic          out_load;

  logic [MAX_WIDTH-1:0] grid_mem_q [MAX_HEIGHT];
  logic [MAX_HEIGHT-1:0] row_vld_q;
  logic [MAX_WIDTH-1:0] rd_q;
  logic                 rd_vld_q;
  logic [MAX_WIDTH-1:0] rd_row;
  logic [RW-1:0]        rd_addr;
  logic                 mem_we;
  logic [RW-1:0]        mem_waddr;
  logic [MAX_WIDTH-1:0] mem_wdata;
  logic                 vld_clr;

  lge_cell_ctrl_t       cell_ctrl;
  logic [MAX_WIDTH-1:0] col_act;
  logic [MAX_WIDTH-1:0] next_row;
  logic [MAX_WIDTH-1:0] new_bits;
  logic [2:0]           win_col [MAX_WIDTH+2];

  logic [1:0] in_action;
  logic [5:0] in_col, in_row;
  logic       in_val;
  logic       in_accept;
  logic       in_oor;
  logic       shift_row_act;
  logic       wr_row_act;

  assign in_action = s_axis_tdata[1:0];
  assign in_col    = s_axis_tdata[7:2];
  assign in_row    = s_axis_tdata[13:8];
  assign in_val    = s_axis_tdata[14];

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_accept     = s_axis_tvalid & s_axis_tready;

  assign in_oor = !((int'(in_col) < int'(grid_width_q)) && (int'(in_col) < MAX_WIDTH) &&
                    (int'(in_row) < int'(grid_height_q)) && (int'(in_row) < MAX_HEIGHT));

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_width_q  <= GRID_DIM_RST;
      grid_height_q <= GRID_DIM_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_GRID_WIDTH:  grid_width_q  <= cfg_data_i;
        CFG_GRID_HEIGHT: grid_height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // row memory
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      grid_mem_q[mem_waddr] <= mem_wdata;
    end
    rd_q     <= grid_mem_q[rd_addr];
    rd_vld_q <= row_vld_q[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q <= '0;
    end else if (vld_clr) begin
      row_vld_q <= '0;
    end else if (mem_we) begin
      row_vld_q[mem_waddr] <= 1'b1;
    end
  end

  assign rd_row = rd_vld_q ? rd_q : '0;

  // cell chain
  assign win_col[0]           = 3'b000;
  assign win_col[MAX_WIDTH+1] = 3'b000;

  for (genvar c = 0; c < MAX_WIDTH; c++) begin : g_cell
    assign col_act[c]  = (c < int'(grid_width_q));
    assign new_bits[c] = rd_row[c] & shift_row_act;

    lge_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (cell_ctrl),
      .act_i   (col_act[c]),
      .bit_i   (new_bits[c]),
      .left_i  (win_col[c]),
      .right_i (win_col[c+2]),
      .col_o   (win_col[c+1]),
      .next_o  (next_row[c])
    );
  end

  assign shift_row_act = (int'(k_q) <= int'(grid_height_q)) && (int'(k_q) <= MAX_HEIGHT);
  assign wr_row_act    = (int'(k_q) - 3 < int'(grid_height_q));

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q        <= op_d;
    col_q       <= col_d;
    row_q       <= row_d;
    val_q       <= val_d;
    res_alive_q <= res_alive_d;
    res_oor_q   <= res_oor_d;
  end

  always_comb begin
    state_d         = state_q;
    op_d            = op_q;
    col_d           = col_q;
    row_d           = row_q;
    val_d           = val_q;
    k_d             = k_q;
    res_alive_d     = res_alive_q;
    res_oor_d       = res_oor_q;
    rd_addr         = row_q;
    mem_we          = 1'b0;
    mem_waddr       = row_q;
    mem_wdata       = rd_row;
    vld_clr         = 1'b0;
    cell_ctrl.init  = 1'b0;
    cell_ctrl.shift = 1'b0;
    out_load        = 1'b0;

    case (state_q)
      ST_IDLE: begin
        rd_addr = RW'(in_row);
        if (in_accept) begin
          op_d        = lge_act_e'(in_action);
          col_d       = CW'(in_col);
          row_d       = RW'(in_row);
          val_d       = in_val;
          res_alive_d = 1'b0;
          res_oor_d   = 1'b0;
          case (lge_act_e'(in_action))
            ACT_WRITE, ACT_READ: begin
              if (in_oor) begin
                res_oor_d = 1'b1;
                state_d   = ST_RESP;
              end else begin
                state_d = ST_RMW;
              end
            end
            ACT_CLEAR: begin
              vld_clr = 1'b1;
              state_d = ST_RESP;
            end
            ACT_STEP: begin
              cell_ctrl.init = 1'b1;
              k_d            = '0;
              state_d        = ST_SWEEP;
            end
            default: state_d = ST_RESP;
          endcase
        end
      end

      ST_RMW: begin
        mem_wdata        = rd_row;
        mem_wdata[col_q] = val_q;
        mem_we           = (op_q == ACT_WRITE);
        res_alive_d      = (op_q == ACT_READ) & rd_row[col_q];
        state_d          = ST_RESP;
      end

      ST_SWEEP: begin
        rd_addr         = (int'(k_q) < MAX_HEIGHT) ? RW'(k_q) : '0;
        cell_ctrl.shift = (k_q != '0);
        if (int'(k_q) >= 3) begin
          mem_we    = 1'b1;
          mem_waddr = RW'(k_q - KW'(3));
          mem_wdata = wr_row_act ? next_row : '0;
        end
        k_d = k_q + KW'(1);
        if (int'(k_q) == MAX_HEIGHT + 2) begin
          state_d = ST_RESP;
        end
      end

      ST_RESP: begin
        if (!out_valid_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_alive_q <= res_alive_q;
      out_oor_q   <= res_oor_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'b000000, out_oor_q, out_alive_q};

endmodule
